// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked and reset-gated
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define EHL_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define EHL_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- rtl/ehl_pkg.sv -----
// ----------------------------------------------------------------------------
// ehl_pkg
// Types and constants of the ethernet to ipv4 header locator
// ----------------------------------------------------------------------------
package ehl_pkg;

    // ether types and ppp protocol
    localparam logic [15:0] ETH_TYPE_VLAN_Q  = 16'h8100;
    localparam logic [15:0] ETH_TYPE_VLAN_AD = 16'h88A8;
    localparam logic [15:0] ETH_TYPE_PPPOE   = 16'h8864;
    localparam logic [15:0] ETH_TYPE_IPV4    = 16'h0800;
    localparam logic [15:0] PPP_IPV4_CODE    = 16'h0021;

    // header geometry
    localparam int MAC_HDR_BYTES  = 14;
    localparam int IPV4_HDR_BYTES = 20;
    localparam int VLAN_TAG_BYTES = 4;
    localparam int PPPOE_HDR_BYTES = 8;

    // parse phases
    typedef enum logic [2:0] {
        PH_MAC,
        PH_VLAN,
        PH_PPPOE,
        PH_IPV4,
        PH_FAIL
    } phase_t;

    // one frame byte
    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_end;
    } frame_item_t;

    // one per-frame result
    typedef struct packed {
        logic        found_ipv4;
        logic [13:0] hdr_offset;
        logic [47:0] source_mac;
        logic [47:0] destination_mac;
        logic        via_pppoe;
    } result_item_t;

endpackage

// ----- rtl/ehl_parser.sv -----
// ----------------------------------------------------------------------------
// ehl_parser
// Per-byte header walk: MACs, vlan tags, pppoe session, result at frame end
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ehl_parser
    import ehl_pkg::*;
#(
    parameter int MAX_PACKET_BYTES = 16384
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         step,
    input  frame_item_t  item,
    output result_item_t result
);

    localparam int POS_W = $clog2(MAX_PACKET_BYTES + 1);
    localparam int CMP_W = POS_W + 1;

    localparam logic [POS_W-1:0] POS_MAX    = POS_W'(MAX_PACKET_BYTES);
    localparam logic [POS_W-1:0] POS_SRC    = POS_W'(6);
    localparam logic [POS_W-1:0] POS_TYPE   = POS_W'(12);
    localparam logic [POS_W-1:0] POS_TYPE_LO = POS_W'(13);
    localparam logic [POS_W-1:0] HS_RESET   = POS_W'(MAC_HDR_BYTES);

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [POS_W-1:0] hs_reg, hs_next;
    logic [47:0]      dest_reg, dest_next;
    logic [47:0]      src_reg, src_next;
    logic [15:0]      fs_reg, fs_next;
    phase_t           phase_reg, phase_next;
    logic             pppoe_reg, pppoe_next;

    logic             long_enough;
    logic             reached;
    logic             fits;

    // phase that follows a completed ether type
    function automatic phase_t type_phase(input logic [15:0] et);
        phase_t ph;
        if (et == ETH_TYPE_VLAN_Q || et == ETH_TYPE_VLAN_AD)
            ph = PH_VLAN;
        else if (et == ETH_TYPE_PPPOE)
            ph = PH_PPPOE;
        else if (et == ETH_TYPE_IPV4)
            ph = PH_IPV4;
        else
            ph = PH_FAIL;
        return ph;
    endfunction

    // byte update
    always_comb
    begin
        pos_next   = pos_reg;
        hs_next    = hs_reg;
        dest_next  = dest_reg;
        src_next   = src_reg;
        fs_next    = fs_reg;
        phase_next = phase_reg;
        pppoe_next = pppoe_reg;

        if (step && (pos_reg < POS_MAX))
        begin
            fs_next  = {fs_reg[7:0], item.data_byte};
            pos_next = pos_reg + POS_W'(1);
            case (phase_reg)
                PH_MAC:
                begin
                    if (pos_reg < POS_SRC)
                        dest_next = {dest_reg[39:0], item.data_byte};
                    else if (pos_reg < POS_TYPE)
                        src_next = {src_reg[39:0], item.data_byte};
                    else if (pos_reg == POS_TYPE_LO)
                        phase_next = type_phase(fs_next);
                end
                PH_VLAN:
                begin
                    if ({1'b0, pos_reg} ==
                        {1'b0, hs_reg} + CMP_W'(VLAN_TAG_BYTES - 1))
                    begin
                        hs_next    = hs_reg + POS_W'(VLAN_TAG_BYTES);
                        phase_next = type_phase(fs_next);
                    end
                end
                PH_PPPOE:
                begin
                    if ({1'b0, pos_reg} ==
                        {1'b0, hs_reg} + CMP_W'(PPPOE_HDR_BYTES - 1))
                    begin
                        if (fs_next != PPP_IPV4_CODE)
                            phase_next = PH_FAIL;
                        else
                        begin
                            hs_next    = hs_reg + POS_W'(PPPOE_HDR_BYTES);
                            pppoe_next = 1'b1;
                            phase_next = PH_IPV4;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end

        // result from the updated state
        long_enough = pos_next >= POS_W'(MAC_HDR_BYTES);
        reached     = phase_next == PH_IPV4;
        fits        = ({1'b0, hs_next} + CMP_W'(IPV4_HDR_BYTES)) <= {1'b0, pos_next};

        result.found_ipv4      = long_enough && reached && fits;
        result.hdr_offset      = result.found_ipv4 ? 14'(hs_next) : 14'd0;
        result.source_mac      = long_enough ? src_next : 48'd0;
        result.destination_mac = long_enough ? dest_next : 48'd0;
        result.via_pppoe       = long_enough && reached && pppoe_next;

        // back to start of frame after the last byte
        if (step && item.frame_end)
        begin
            pos_next   = '0;
            hs_next    = HS_RESET;
            dest_next  = '0;
            src_next   = '0;
            fs_next    = '0;
            phase_next = PH_MAC;
            pppoe_next = 1'b0;
        end
    end

    // parse state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            hs_reg    <= HS_RESET;
            dest_reg  <= '0;
            src_reg   <= '0;
            fs_reg    <= '0;
            phase_reg <= PH_MAC;
            pppoe_reg <= 1'b0;
        end
        else
        begin
            pos_reg   <= pos_next;
            hs_reg    <= hs_next;
            dest_reg  <= dest_next;
            src_reg   <= src_next;
            fs_reg    <= fs_next;
            phase_reg <= phase_next;
            pppoe_reg <= pppoe_next;
        end
    end

    // a frame end returns the walk to its start
    `EHL_ASSERT_NEXT(a_frame_restart, clk, rst_n, step && item.frame_end,
        pos_reg == '0 && phase_reg == PH_MAC && hs_reg == HS_RESET)
    // pppoe only ever leads to the ipv4 phase
    `EHL_ASSERT_IMPL(a_pppoe_ipv4, clk, rst_n, pppoe_reg, phase_reg == PH_IPV4)

endmodule

// ----- rtl/ehl_result_queue.sv -----
// ----------------------------------------------------------------------------
// ehl_result_queue
// Output register plus skid entry for per-frame results
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ehl_result_queue
    import ehl_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  result_item_t push_item,
    output logic         space,
    output logic         result_valid,
    input  logic         result_stall,
    output result_item_t result_data
);

    logic         out_valid_reg, out_valid_next;
    result_item_t out_item_reg, out_item_next;
    logic         skid_valid_reg, skid_valid_next;
    result_item_t skid_item_reg, skid_item_next;
    logic         pop;

    assign pop          = out_valid_reg && !result_stall;
    assign space        = !skid_valid_reg;
    assign result_valid = out_valid_reg;
    assign result_data  = out_item_reg;

    // entry movement
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_item_next   = out_item_reg;
        skid_valid_next = skid_valid_reg;
        skid_item_next  = skid_item_reg;
        if (!out_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_item_next   = skid_item_reg;
                skid_valid_next = push;
                skid_item_next  = push_item;
            end
            else
            begin
                out_valid_next = push;
                out_item_next  = push_item;
            end
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_item_next  = push_item;
        end
    end

    // valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        out_item_reg  <= out_item_next;
        skid_item_reg <= skid_item_next;
    end

    // skid entry is only used behind a held output
    `EHL_ASSERT_IMPL(a_skid_order, clk, rst_n, skid_valid_reg, out_valid_reg)
    // no push into a full queue
    `EHL_ASSERT_IMPL(a_no_overflow, clk, rst_n, push, !skid_valid_reg)

endmodule

// ----- rtl/ethernet_to_ipv4_header_locator_top.sv -----
// ----------------------------------------------------------------------------
// ethernet_to_ipv4_header_locator_top
// Locates the ipv4 header behind ethernet, vlan tags and a pppoe session
// ----------------------------------------------------------------------------
// Usage:
// frame_* carries one frame byte per item, first byte of the destination MAC
// first; frame_end marks the final byte. result_* carries one item per frame:
// found flag, ipv4 header offset, both MACs and the pppoe flag.
// An item moves when valid is high and stall is low.
// Throughput: one byte per cycle while frame_stall is low, back to back across frames.
// Path: a byte lands in the input register when accepted and is parsed from
// there; the final byte's result is formed combinationally and pushed into the
// output register, or into the skid entry while the output holds a stalled result.
// The result side has an output register and one skid entry; frame_stall
// rises only when a final byte waits while both hold undelivered results.
// Reset empties both channels and starts the parser at a new frame.
// Frames longer than MAX_PACKET_BYTES are counted up to that length only.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ethernet_to_ipv4_header_locator_top
    import ehl_pkg::*;
#(
    parameter int MAX_PACKET_BYTES = 16384
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         frame_valid,
    output logic         frame_stall,
    input  frame_item_t  frame_data,
    output logic         result_valid,
    input  logic         result_stall,
    output result_item_t result_data
);

    logic         in_valid_reg, in_valid_next;
    frame_item_t  in_item_reg;
    logic         accept;
    logic         advance;
    logic         space;
    result_item_t parsed;

    // input register control
    assign advance     = in_valid_reg && (!in_item_reg.frame_end || space);
    assign frame_stall = in_valid_reg && !advance;
    assign accept      = frame_valid && !frame_stall;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (accept)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            in_item_reg <= frame_data;
    end

    // header walk
    ehl_parser #(
        .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
    ) u_parser (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (in_item_reg),
        .result (parsed)
    );

    // result buffering
    ehl_result_queue u_queue (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (advance && in_item_reg.frame_end),
        .push_item    (parsed),
        .space        (space),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data)
    );

    // input stalls only behind a waiting final byte
    `EHL_ASSERT_IMPL(a_stall_final, clk, rst_n, frame_stall, in_valid_reg && in_item_reg.frame_end)
    // a stalled result stays put
    `EHL_ASSERT_NEXT(a_result_hold, clk, rst_n, result_valid && result_stall, result_valid && $stable(result_data))

endmodule
